/* hw/rtl/ycb_pkg.sv */
package ycb_pkg;

  // defaults of the top level parameters
  localparam int MAX_WIDTH_DEF      = 4096;
  localparam int MAX_HEIGHT_DEF     = 4096;
  localparam int COEF_FRAC_BITS_DEF = 12;

  // field widths
  localparam int DIM_REG_W = 13;
  localparam int DIM_W     = 14;
  localparam int GAIN_W    = 14;
  localparam int COORD_W   = 13;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 14;
  localparam int IDX_W     = 24;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LUMA_GAIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_CR_GAIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN_CB_GAIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN_CR_GAIN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BLUE_CB_GAIN  = 3'd6;

  // register reset values
  localparam logic [DIM_REG_W-1:0] FRAME_WIDTH_RST   = 13'd640;
  localparam logic [DIM_REG_W-1:0] FRAME_HEIGHT_RST  = 13'd480;
  localparam logic [GAIN_W-1:0]    LUMA_GAIN_RST     = 14'd4769;
  localparam logic [GAIN_W-1:0]    RED_CR_GAIN_RST   = 14'd6537;
  localparam logic [GAIN_W-1:0]    GREEN_CB_GAIN_RST = 14'd1605;
  localparam logic [GAIN_W-1:0]    GREEN_CR_GAIN_RST = 14'd3330;
  localparam logic [GAIN_W-1:0]    BLUE_CB_GAIN_RST  = 14'd8263;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // effective settings seen by front and back
  typedef struct packed {
    logic [DIM_W-1:0]     width;
    logic [DIM_REG_W-1:0] width_m1;
    logic [DIM_REG_W-1:0] height_m1;
    logic [GAIN_W-1:0]    luma_gain;
    logic [GAIN_W-1:0]    red_cr_gain;
    logic [GAIN_W-1:0]    green_cb_gain;
    logic [GAIN_W-1:0]    green_cr_gain;
    logic [GAIN_W-1:0]    blue_cb_gain;
  } cfg_t;

  // one classified pixel: luma, its chroma pair and its position
  typedef struct packed {
    logic [7:0]         luma;
    logic [15:0]        pair;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } pix_t;

endpackage

/* hw/rtl/ycb_if.sv */
interface ycb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma;
  logic [7:0] chroma_blue;
  logic [7:0] chroma_red;

  modport source(output valid, luma, chroma_blue, chroma_red, input ready);
  modport sink(input valid, luma, chroma_blue, chroma_red, output ready);
endinterface

interface ycb_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  blue_out;
  logic [7:0]  green_out;
  logic [7:0]  red_out;
  logic [23:0] pixel_index;
  logic        frame_end;

  modport source(output valid, blue_out, green_out, red_out, pixel_index, frame_end,
                 input ready);
  modport sink(input valid, blue_out, green_out, red_out, pixel_index, frame_end,
               output ready);
endinterface

/* hw/rtl/ycb_ram.sv */
module ycb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/ycb_queue.sv */
module ycb_queue (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  ycb_pkg::pix_t             push_data,
  input  logic                      pop,
  output logic                      q_valid,
  output ycb_pkg::pix_t             q_data,
  output logic [ycb_pkg::QCNT_W-1:0] q_count
);

  ycb_pkg::pix_t                  mem_r [ycb_pkg::QUEUE_DEPTH];
  logic [ycb_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [ycb_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [ycb_pkg::QCNT_W-1:0]     count_r, count_nxt;

  assign q_valid = (count_r != '0);
  assign q_data  = mem_r[rd_ptr_r];
  assign q_count = count_r;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + ycb_pkg::QCNT_W'(push) - ycb_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* hw/rtl/ycb_front.sv */
module ycb_front #(
  parameter int MAX_WIDTH  = ycb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = ycb_pkg::MAX_HEIGHT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  ycb_in_if.sink                     in_ch,
  input  ycb_pkg::cfg_t              cfg,
  input  logic                       restart,
  input  logic [ycb_pkg::QCNT_W-1:0] q_count,
  output logic                       push,
  output ycb_pkg::pix_t              push_data
);

  localparam int CW         = $clog2(MAX_WIDTH);
  localparam int RW         = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int LA_W       = $clog2(LINE_DEPTH);

  logic [CW-1:0]  col_r, col_nxt;
  logic [RW-1:0]  row_r, row_nxt;
  logic [15:0]    held_r, held_nxt;
  logic           s1_valid_r;
  logic           s1_from_line_r;
  ycb_pkg::pix_t  s1_pix_r, s1_pix_nxt;

  logic           accept;
  logic           take_pair;
  logic           last_col;
  logic           last_row;
  logic [15:0]    new_pair;
  logic [15:0]    line_rdata;

  // room for the word in flight plus the one being taken
  assign in_ch.ready = (q_count + ycb_pkg::QCNT_W'(s1_valid_r))
                       < ycb_pkg::QCNT_W'(ycb_pkg::QUEUE_DEPTH);
  assign accept      = in_ch.valid && in_ch.ready;

  assign new_pair  = {in_ch.chroma_blue, in_ch.chroma_red};
  assign take_pair = accept && !row_r[0] && !col_r[0];
  assign last_col  = (ycb_pkg::COORD_W'(col_r) == cfg.width_m1);
  assign last_row  = (ycb_pkg::COORD_W'(row_r) == cfg.height_m1);

  always_comb begin
    held_nxt = take_pair ? new_pair : held_r;
    col_nxt  = col_r;
    row_nxt  = row_r;
    if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
    s1_pix_nxt.luma = in_ch.luma;
    s1_pix_nxt.pair = held_nxt;
    s1_pix_nxt.col  = ycb_pkg::COORD_W'(col_r);
    s1_pix_nxt.row  = ycb_pkg::COORD_W'(row_r);
  end

  // half-width chroma line, written on even rows, read on odd rows
  ycb_ram #(
    .WIDTH(16),
    .DEPTH(LINE_DEPTH)
  ) u_line (
    .clk  (clk),
    .we   (take_pair),
    .waddr(col_r[LA_W:1]),
    .wdata(new_pair),
    .raddr(col_r[LA_W:1]),
    .rdata(line_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      held_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      held_r     <= held_nxt;
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r       <= s1_pix_nxt;
      s1_from_line_r <= row_r[0];
    end
  end

  always_comb begin
    push      = s1_valid_r;
    push_data = s1_pix_r;
    if (s1_from_line_r) begin
      push_data.pair = line_rdata;
    end
  end

endmodule

/* hw/rtl/ycb_back.sv */
module ycb_back #(
  parameter int COEF_FRAC_BITS = ycb_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ycb_pkg::cfg_t cfg,
  input  logic          q_valid,
  input  ycb_pkg::pix_t q_data,
  output logic          pop,
  ycb_out_if.source     out_ch
);

  localparam int ACC_W = 27;
  localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) << (COEF_FRAC_BITS - 1);

  logic                         b1_valid_r;
  logic signed [23:0]           b1_py_r, b1_pbu_r, b1_pgu_r, b1_pgv_r, b1_prv_r;
  logic [ycb_pkg::IDX_W-1:0]    b1_idx_r;
  logic [ycb_pkg::COORD_W-1:0]  b1_col_r;
  logic                         b1_last_r;

  logic                         out_valid_r;
  logic [7:0]                   blue_r, green_r, red_r;
  logic [ycb_pkg::IDX_W-1:0]    index_r;
  logic                         last_r;

  logic                         out_adv;
  logic                         b1_adv;

  logic signed [8:0]            y_s, u_s, v_s;
  logic signed [14:0]           gl_s, gbu_s, ggu_s, ggv_s, grv_s;
  logic signed [23:0]           py, pbu, pgu, pgv, prv;
  logic [ycb_pkg::COORD_W-1:0]  rows_left;
  logic [26:0]                  idx_full;
  logic                         is_last;
  logic signed [ACC_W-1:0]      acc_b, acc_g, acc_r;

  function automatic logic signed [ACC_W-1:0] sx(input logic signed [23:0] p);
    sx = {{(ACC_W-24){p[23]}}, p};
  endfunction

  // half up rounding, then clamp to 0..255
  function automatic logic [7:0] round_clamp(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] s;
    logic signed [ACC_W-1:0] sh;
    s  = acc + RND;
    sh = s >>> COEF_FRAC_BITS;
    if (s < 0) begin
      round_clamp = 8'd0;
    end else if (sh > 27'sd255) begin
      round_clamp = 8'd255;
    end else begin
      round_clamp = sh[7:0];
    end
  endfunction

  assign out_adv = !out_valid_r || out_ch.ready;
  assign b1_adv  = !b1_valid_r || out_adv;
  assign pop     = q_valid && b1_adv;

  // stage one: offsets, products, row base of the index and the last flag
  always_comb begin
    y_s   = $signed({1'b0, q_data.luma}) - 9'sd16;
    u_s   = $signed({1'b0, q_data.pair[15:8]}) - 9'sd128;
    v_s   = $signed({1'b0, q_data.pair[7:0]}) - 9'sd128;
    gl_s  = $signed({1'b0, cfg.luma_gain});
    gbu_s = $signed({1'b0, cfg.blue_cb_gain});
    ggu_s = $signed({1'b0, cfg.green_cb_gain});
    ggv_s = $signed({1'b0, cfg.green_cr_gain});
    grv_s = $signed({1'b0, cfg.red_cr_gain});
    py    = y_s * gl_s;
    pbu   = u_s * gbu_s;
    pgu   = u_s * ggu_s;
    pgv   = v_s * ggv_s;
    prv   = v_s * grv_s;
    rows_left = cfg.height_m1 - q_data.row;
    idx_full  = rows_left * cfg.width;
    is_last   = (q_data.row == cfg.height_m1) && (q_data.col == cfg.width_m1);
  end

  // stage two: sums, rounding, index
  always_comb begin
    acc_b = sx(b1_py_r) + sx(b1_pbu_r);
    acc_g = sx(b1_py_r) - sx(b1_pgu_r) - sx(b1_pgv_r);
    acc_r = sx(b1_py_r) + sx(b1_prv_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (b1_adv) begin
        b1_valid_r <= q_valid;
      end
      if (out_adv) begin
        out_valid_r <= b1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b1_py_r   <= py;
      b1_pbu_r  <= pbu;
      b1_pgu_r  <= pgu;
      b1_pgv_r  <= pgv;
      b1_prv_r  <= prv;
      b1_idx_r  <= idx_full[ycb_pkg::IDX_W-1:0];
      b1_col_r  <= q_data.col;
      b1_last_r <= is_last;
    end
    if (out_adv && b1_valid_r) begin
      blue_r  <= round_clamp(acc_b);
      green_r <= round_clamp(acc_g);
      red_r   <= round_clamp(acc_r);
      index_r <= b1_idx_r + ycb_pkg::IDX_W'(b1_col_r);
      last_r  <= b1_last_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.blue_out    = blue_r;
  assign out_ch.green_out   = green_r;
  assign out_ch.red_out     = red_r;
  assign out_ch.pixel_index = index_r;
  assign out_ch.frame_end   = last_r;

endmodule

/* hw/rtl/ycbcr420_to_bgr_converter.sv */
// 4:2:0 YCbCr to BGR pixel converter. Luma words arrive in raster order on in_ch, each with
// a Cb/Cr pair that is only sampled at even rows and even columns; that pair serves two
// pixels and is stored in a half-width chroma line so that the following odd row reuses it
// (nearest-neighbour upsampling). Every pixel is converted with BT.601 limited-range gains
// in unsigned Q2.COEF_FRAC_BITS, rounded half up and clamped to 0..255, and leaves on
// out_ch as blue, green, red with its bottom-up pixel index and a frame end flag. The block
// sustains one pixel per clock while out_ch.ready is high, passing it through the chroma line
// read, queue, product stage and output register. The chroma line, (MAX_WIDTH+1)/2 entries
// of 16 bits, is not cleared after reset: an odd row must follow the even row that filled it.
// The user writes registers via cfg_we/cfg_index/cfg_data only while no pixel is in flight;
// the block does not enforce it. Writing frame_width/frame_height restarts at row 0, column 0.
module ycbcr420_to_bgr_converter #(
  parameter int MAX_WIDTH      = ycb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT     = ycb_pkg::MAX_HEIGHT_DEF,
  parameter int COEF_FRAC_BITS = ycb_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  ycb_in_if.sink                        in_ch,
  ycb_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [ycb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ycb_pkg::CFG_DAT_W-1:0] cfg_data
);

  // configuration registers
  logic [ycb_pkg::DIM_REG_W-1:0] frame_width_r;
  logic [ycb_pkg::DIM_REG_W-1:0] frame_height_r;
  logic [ycb_pkg::GAIN_W-1:0]    luma_gain_r;
  logic [ycb_pkg::GAIN_W-1:0]    red_cr_gain_r;
  logic [ycb_pkg::GAIN_W-1:0]    green_cb_gain_r;
  logic [ycb_pkg::GAIN_W-1:0]    green_cr_gain_r;
  logic [ycb_pkg::GAIN_W-1:0]    blue_cb_gain_r;

  logic [ycb_pkg::DIM_W-1:0]     width_eff;
  logic [ycb_pkg::DIM_W-1:0]     height_eff;
  logic                          restart;
  ycb_pkg::cfg_t                 cfg;

  logic                          push;
  ycb_pkg::pix_t                 push_data;
  logic                          pop;
  logic                          q_valid;
  ycb_pkg::pix_t                 q_data;
  logic [ycb_pkg::QCNT_W-1:0]    q_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r   <= ycb_pkg::FRAME_WIDTH_RST;
      frame_height_r  <= ycb_pkg::FRAME_HEIGHT_RST;
      luma_gain_r     <= ycb_pkg::LUMA_GAIN_RST;
      red_cr_gain_r   <= ycb_pkg::RED_CR_GAIN_RST;
      green_cb_gain_r <= ycb_pkg::GREEN_CB_GAIN_RST;
      green_cr_gain_r <= ycb_pkg::GREEN_CR_GAIN_RST;
      blue_cb_gain_r  <= ycb_pkg::BLUE_CB_GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ycb_pkg::CFG_FRAME_WIDTH:   frame_width_r   <= cfg_data[ycb_pkg::DIM_REG_W-1:0];
        ycb_pkg::CFG_FRAME_HEIGHT:  frame_height_r  <= cfg_data[ycb_pkg::DIM_REG_W-1:0];
        ycb_pkg::CFG_LUMA_GAIN:     luma_gain_r     <= cfg_data;
        ycb_pkg::CFG_RED_CR_GAIN:   red_cr_gain_r   <= cfg_data;
        ycb_pkg::CFG_GREEN_CB_GAIN: green_cb_gain_r <= cfg_data;
        ycb_pkg::CFG_GREEN_CR_GAIN: green_cr_gain_r <= cfg_data;
        ycb_pkg::CFG_BLUE_CB_GAIN:  blue_cb_gain_r  <= cfg_data;
        default: begin
          // unused index, write is dropped
        end
      endcase
    end
  end

  // geometry change restarts the frame counters
  assign restart = cfg_we && ((cfg_index == ycb_pkg::CFG_FRAME_WIDTH) ||
                              (cfg_index == ycb_pkg::CFG_FRAME_HEIGHT));

  // width and height saturated to 1..max
  always_comb begin
    if (frame_width_r == '0) begin
      width_eff = ycb_pkg::DIM_W'(1);
    end else if ({1'b0, frame_width_r} > ycb_pkg::DIM_W'(MAX_WIDTH)) begin
      width_eff = ycb_pkg::DIM_W'(MAX_WIDTH);
    end else begin
      width_eff = {1'b0, frame_width_r};
    end
    if (frame_height_r == '0) begin
      height_eff = ycb_pkg::DIM_W'(1);
    end else if ({1'b0, frame_height_r} > ycb_pkg::DIM_W'(MAX_HEIGHT)) begin
      height_eff = ycb_pkg::DIM_W'(MAX_HEIGHT);
    end else begin
      height_eff = {1'b0, frame_height_r};
    end
    cfg.width         = width_eff;
    cfg.width_m1      = ycb_pkg::DIM_REG_W'(width_eff - 1'b1);
    cfg.height_m1     = ycb_pkg::DIM_REG_W'(height_eff - 1'b1);
    cfg.luma_gain     = luma_gain_r;
    cfg.red_cr_gain   = red_cr_gain_r;
    cfg.green_cb_gain = green_cb_gain_r;
    cfg.green_cr_gain = green_cr_gain_r;
    cfg.blue_cb_gain  = blue_cb_gain_r;
  end

  // front: counters, chroma hold and chroma line
  ycb_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg      (cfg),
    .restart  (restart),
    .q_count  (q_count),
    .push     (push),
    .push_data(push_data)
  );

  // short queue so either side can stall on its own
  ycb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_count  (q_count)
  );

  // back: color math, index and output register
  ycb_back #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .q_valid(q_valid),
    .q_data (q_data),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

// self-checking bench for the 4:2:0 to bgr pixel converter
module tb_top;
  import ycb_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 5;
  localparam int LINE_DEPTH   = (MAX_WIDTH_DEF + 1) / 2;
  localparam int RAND_PHASES  = 16;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD    = 300;
  localparam int HOLD_PHASE   = 4;
  localparam int END_CYCLES   = 20;
  localparam int LIMIT_CYCLES = 400000;

  // index past the last register, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef enum int {
    SEND_LIGHT_RECV_HEAVY,
    SEND_HEAVY_RECV_LIGHT,
    NO_IDLING
  } idle_mode_e;

  // one input word: luma with the chroma pair beside it
  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] cb;
    logic [7:0] cr;
  } ycc_word_t;

  // one converted pixel as it leaves the block
  typedef struct packed {
    logic [7:0]       blue;
    logic [7:0]       green;
    logic [7:0]       red;
    logic [IDX_W-1:0] index;
    logic             frame_end;
  } bgr_word_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data  = '0;

  ycb_in_if  in_ch();
  ycb_out_if out_ch();

  ycbcr420_to_bgr_converter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // words waiting to be offered, and pixels expected back in order
  ycc_word_t pending_px[$];
  bgr_word_t expected_bgr[$];
  bgr_word_t oldest_bgr;
  int        fail_count = 0;

  // idle rates in percent, set per phase
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // long receiver hold-off, requested by toggling hold_req
  logic hold_req  = 1'b0;
  logic hold_ack  = 1'b0;
  int   hold_left = 0;

  // mirror of the register file
  logic [DIM_REG_W-1:0] width_reg     = FRAME_WIDTH_RST;
  logic [DIM_REG_W-1:0] height_reg    = FRAME_HEIGHT_RST;
  logic [GAIN_W-1:0]    luma_gain     = LUMA_GAIN_RST;
  logic [GAIN_W-1:0]    red_cr_gain   = RED_CR_GAIN_RST;
  logic [GAIN_W-1:0]    green_cb_gain = GREEN_CB_GAIN_RST;
  logic [GAIN_W-1:0]    green_cr_gain = GREEN_CR_GAIN_RST;
  logic [GAIN_W-1:0]    blue_cb_gain  = BLUE_CB_GAIN_RST;

  // raster position and chroma storage of the predictor
  int unsigned col_cnt   = 0;
  int unsigned row_cnt   = 0;
  logic [15:0] held_pair = '0;
  logic [15:0] chroma_line [LINE_DEPTH];

  // geometry registers saturate to 1..max
  function automatic int unsigned sat_dim(int unsigned v, int unsigned max_v);
    if (v < 1) return 1;
    if (v > max_v) return max_v;
    return v;
  endfunction

  // add half an lsb, floor-divide by the coefficient scale, clamp to a byte
  function automatic logic [7:0] round_clamp(longint acc);
    longint s;
    s = acc + (longint'(1) <<< (COEF_FRAC_BITS_DEF - 1));
    if (s < 0) return 8'd0;
    s = s >>> COEF_FRAC_BITS_DEF;
    return (s > 255) ? 8'd255 : s[7:0];
  endfunction

  // converts one accepted word and steps the raster position
  function automatic bgr_word_t convert_pixel(ycc_word_t px);
    int unsigned w, h, col, row, slot;
    logic [15:0] pair;
    longint      y, u, v, luma_term;
    bgr_word_t   res;
    w   = sat_dim(width_reg, MAX_WIDTH_DEF);
    h   = sat_dim(height_reg, MAX_HEIGHT_DEF);
    col = (col_cnt >= w) ? w - 1 : col_cnt;
    row = (row_cnt >= h) ? h - 1 : row_cnt;
    slot = (col >> 1) % LINE_DEPTH;
    // even rows sample the pair at even columns and store it, odd rows reuse it
    if (row % 2 == 0) begin
      if (col % 2 == 0) begin
        held_pair         = {px.cb, px.cr};
        chroma_line[slot] = held_pair;
      end
      pair = held_pair;
    end else begin
      pair = chroma_line[slot];
    end
    y = longint'(px.luma) - 16;
    u = longint'(pair[15:8]) - 128;
    v = longint'(pair[7:0]) - 128;
    luma_term     = longint'(luma_gain) * y;
    res.blue      = round_clamp(luma_term + longint'(blue_cb_gain) * u);
    res.green     = round_clamp(luma_term - longint'(green_cb_gain) * u
                                - longint'(green_cr_gain) * v);
    res.red       = round_clamp(luma_term + longint'(red_cr_gain) * v);
    // bottom-up position, kept to 24 bits
    res.index     = IDX_W'(longint'(h - 1 - row) * w + col);
    res.frame_end = (row == h - 1) && (col == w - 1);
    if (col == w - 1) begin
      col_cnt = 0;
      row_cnt = (row == h - 1) ? 0 : row + 1;
    end else begin
      col_cnt = col + 1;
      row_cnt = row;
    end
    return res;
  endfunction

  function automatic void push_pixel(logic [7:0] luma, logic [7:0] cb, logic [7:0] cr);
    pending_px.push_back('{luma, cb, cr});
  endfunction

  // one of the interesting sample levels: black, white, zero chroma, rails
  function automatic logic [7:0] pick_level();
    case ($urandom_range(4))
      0:       return 8'd0;
      1:       return 8'd16;
      2:       return 8'd128;
      3:       return 8'd235;
      default: return 8'd255;
    endcase
  endfunction

  task automatic set_idling(idle_mode_e mode);
    case (mode)
      SEND_LIGHT_RECV_HEAVY: begin
        send_idle_pct <= 27;
        recv_idle_pct <= 67;
      end
      SEND_HEAVY_RECV_LIGHT: begin
        send_idle_pct <= 67;
        recv_idle_pct <= 27;
      end
      default: begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
    endcase
  endtask

  // register write, mirrored into the predictor at the same time
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      // geometry writes restart the frame, chroma storage is kept
      CFG_FRAME_WIDTH: begin
        width_reg = val[DIM_REG_W-1:0];
        col_cnt   = 0;
        row_cnt   = 0;
      end
      CFG_FRAME_HEIGHT: begin
        height_reg = val[DIM_REG_W-1:0];
        col_cnt    = 0;
        row_cnt    = 0;
      end
      CFG_LUMA_GAIN:     luma_gain     = val[GAIN_W-1:0];
      CFG_RED_CR_GAIN:   red_cr_gain   = val[GAIN_W-1:0];
      CFG_GREEN_CB_GAIN: green_cb_gain = val[GAIN_W-1:0];
      CFG_GREEN_CR_GAIN: green_cr_gain = val[GAIN_W-1:0];
      CFG_BLUE_CB_GAIN:  blue_cb_gain  = val[GAIN_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // waits until every word is sent and every pixel is back, then lets the pipeline settle
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_px.size() != 0 || in_ch.valid || expected_bgr.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // driver: holds a word until it is taken, then maybe idles before the next
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_bgr.push_back(convert_pixel(pending_px.pop_front()));
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_px.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid       <= 1'b1;
          in_ch.luma        <= pending_px[0].luma;
          in_ch.chroma_blue <= pending_px[0].cb;
          in_ch.chroma_red  <= pending_px[0].cr;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // hold-off counter, runs on its own so the monitor only sees the count
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_left <= LONG_HOLD;
      hold_ack  <= hold_req;
    end
  end

  // monitor: compares every taken word against the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_bgr.size() == 0) begin
          $error("unexpected word: pixel_index %0d", out_ch.pixel_index);
          fail_count++;
        end else begin
          oldest_bgr = expected_bgr.pop_front();
          if (out_ch.blue_out !== oldest_bgr.blue) begin
            $error("blue_out: expected %0d, actual %0d", oldest_bgr.blue, out_ch.blue_out);
            fail_count++;
          end
          if (out_ch.green_out !== oldest_bgr.green) begin
            $error("green_out: expected %0d, actual %0d", oldest_bgr.green, out_ch.green_out);
            fail_count++;
          end
          if (out_ch.red_out !== oldest_bgr.red) begin
            $error("red_out: expected %0d, actual %0d", oldest_bgr.red, out_ch.red_out);
            fail_count++;
          end
          if (out_ch.pixel_index !== oldest_bgr.index) begin
            $error("pixel_index: expected %0d, actual %0d", oldest_bgr.index,
                   out_ch.pixel_index);
            fail_count++;
          end
          if (out_ch.frame_end !== oldest_bgr.frame_end) begin
            $error("frame_end: expected %0d, actual %0d", oldest_bgr.frame_end,
                   out_ch.frame_end);
            fail_count++;
          end
        end
      end
      out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // stimulus and phase sequencing
  initial begin
    int unsigned          geo;
    int unsigned          n_items;
    logic                 rail_gains;
    logic [CFG_DAT_W-1:0] w_val;
    logic [CFG_DAT_W-1:0] h_val;
    in_ch.valid       = 1'b0;
    in_ch.luma        = '0;
    in_ch.chroma_blue = '0;
    in_ch.chroma_red  = '0;
    out_ch.ready      = 1'b0;
    set_idling(SEND_LIGHT_RECV_HEAVY);
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings, 640 x 480: rails of luma and chroma on the top row
    push_pixel(8'd255, 8'd0, 8'd255);
    push_pixel(8'd0, 8'd255, 8'd0);
    push_pixel(8'd16, 8'd128, 8'd128);
    push_pixel(8'd235, 8'd255, 8'd255);
    push_pixel(8'd128, 8'd0, 8'd0);
    push_pixel(8'd255, 8'd255, 8'd0);
    wait_idle();

    // zero gains, zero geometry saturates to 1 x 1: every word ends a frame
    write_reg(CFG_LUMA_GAIN, '0);
    write_reg(CFG_RED_CR_GAIN, '0);
    write_reg(CFG_GREEN_CB_GAIN, '0);
    write_reg(CFG_GREEN_CR_GAIN, '0);
    write_reg(CFG_BLUE_CB_GAIN, '0);
    write_reg(CFG_FRAME_WIDTH, '0);
    write_reg(CFG_FRAME_HEIGHT, '0);
    push_pixel(8'd255, 8'd255, 8'd255);
    push_pixel(8'd0, 8'd0, 8'd0);
    push_pixel(8'd200, 8'd17, 8'd99);
    wait_idle();

    // full-scale gains on a 3 x 2 frame: odd width, odd row reuse, wrap
    write_reg(CFG_LUMA_GAIN, 14'h3FFF);
    write_reg(CFG_RED_CR_GAIN, 14'h3FFF);
    write_reg(CFG_GREEN_CB_GAIN, 14'h3FFF);
    write_reg(CFG_GREEN_CR_GAIN, 14'h3FFF);
    write_reg(CFG_BLUE_CB_GAIN, 14'h3FFF);
    write_reg(CFG_FRAME_WIDTH, 14'd3);
    write_reg(CFG_FRAME_HEIGHT, 14'd2);
    push_pixel(8'd128, 8'd0, 8'd255);
    push_pixel(8'd128, 8'd255, 8'd0);
    push_pixel(8'd16, 8'd255, 8'd0);
    push_pixel(8'd235, 8'd1, 8'd2);
    push_pixel(8'd0, 8'd3, 8'd4);
    push_pixel(8'd255, 8'd5, 8'd6);
    push_pixel(8'd100, 8'd128, 8'd128);
    wait_idle();

    // oversized geometry saturates to 4096 x 4096, index near its top;
    // the unused register index must leave everything alone
    write_reg(CFG_LUMA_GAIN, LUMA_GAIN_RST);
    write_reg(CFG_RED_CR_GAIN, RED_CR_GAIN_RST);
    write_reg(CFG_GREEN_CB_GAIN, GREEN_CB_GAIN_RST);
    write_reg(CFG_GREEN_CR_GAIN, GREEN_CR_GAIN_RST);
    write_reg(CFG_BLUE_CB_GAIN, BLUE_CB_GAIN_RST);
    write_reg(CFG_FRAME_WIDTH, 14'h3FFF);
    write_reg(CFG_FRAME_HEIGHT, 14'd5000);
    write_reg(CFG_UNUSED, 14'h3FFF);
    push_pixel(8'd81, 8'd90, 8'd240);
    push_pixel(8'd145, 8'd54, 8'd34);
    push_pixel(8'd41, 8'd240, 8'd110);
    wait_idle();

    // random phases: idling pattern changes by thirds
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      set_idling(idle_mode_e'(ph * 3 / RAND_PHASES));

      // gains: nominal, fully random, or pinned to the rails
      if ($urandom_range(2) == 0) begin
        write_reg(CFG_LUMA_GAIN, LUMA_GAIN_RST);
        write_reg(CFG_RED_CR_GAIN, RED_CR_GAIN_RST);
        write_reg(CFG_GREEN_CB_GAIN, GREEN_CB_GAIN_RST);
        write_reg(CFG_GREEN_CR_GAIN, GREEN_CR_GAIN_RST);
        write_reg(CFG_BLUE_CB_GAIN, BLUE_CB_GAIN_RST);
      end else begin
        rail_gains = $urandom_range(1);
        for (int g = CFG_LUMA_GAIN; g <= CFG_BLUE_CB_GAIN; g++)
          write_reg(CFG_IDX_W'(g), rail_gains ? ($urandom_range(1) ? 14'h3FFF : 14'h0)
                                              : CFG_DAT_W'($urandom_range(16383)));
      end
      if ($urandom_range(3) == 0)
        write_reg(CFG_UNUSED, CFG_DAT_W'($urandom_range(16383)));

      // geometry: mostly small frames so many frames complete; some phases
      // keep the old geometry and carry on mid-frame
      if (ph == 0 || $urandom_range(3) != 0) begin
        geo = $urandom_range(9);
        case (geo)
          0: begin
            w_val = '0;
            h_val = CFG_DAT_W'($urandom_range(1, 8));
          end
          1: begin
            w_val = 14'd16;
            h_val = 14'd1;
          end
          2: begin
            w_val = 14'd16;
            h_val = 14'd4096;
          end
          3: begin
            w_val = CFG_DAT_W'($urandom_range(16383));
            h_val = CFG_DAT_W'($urandom_range(16383));
          end
          default: begin
            w_val = CFG_DAT_W'($urandom_range(1, 24));
            h_val = CFG_DAT_W'($urandom_range(1, 6));
          end
        endcase
        write_reg(CFG_FRAME_WIDTH, w_val);
        write_reg(CFG_FRAME_HEIGHT, h_val);
      end

      n_items = $urandom_range(60, 170);
      for (int k = 0; k < n_items; k++) begin
        if ($urandom_range(4) == 0)
          push_pixel(pick_level(), pick_level(), pick_level());
        else
          push_pixel(8'($urandom), 8'($urandom), 8'($urandom));
      end

      // receiver stalls while words keep coming: pipeline fills, input backs up
      if (ph == HOLD_PHASE)
        hold_req <= ~hold_req;
      wait_idle();
    end

    repeat (END_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_bgr.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // watchdog
  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("Regression FAIL");
    $finish;
  end

endmodule
